### sv/rsi_sma_pkg.sv
// ----------------------------------------------------------------------------
// rsi_sma_pkg
// Shared sizes, state codes and controller/datapath link types for the
// moving-window relative strength index block.
// ----------------------------------------------------------------------------
package rsi_sma_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int ADDR_W     = $clog2(MAX_WINDOW);
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int PRICE_W    = 24;
  localparam int WIN_W      = 7;
  localparam int SUM_W      = PRICE_W + ADDR_W;
  localparam int RSI_W      = 15;
  localparam int PROD_W     = SUM_W + RSI_W;
  localparam int DIV_CNT_W  = $clog2(RSI_W + 1);
  localparam int RSI_SCALE  = 25600;
  localparam int WIN_RESET  = 15;
  localparam int WIN_MIN    = 2;

  // controller states
  localparam int STATE_W = 3;
  localparam logic [STATE_W-1:0] ST_IDLE = 3'd0;
  localparam logic [STATE_W-1:0] ST_READ = 3'd1;
  localparam logic [STATE_W-1:0] ST_UPD  = 3'd2;
  localparam logic [STATE_W-1:0] ST_MUL  = 3'd3;
  localparam logic [STATE_W-1:0] ST_LOAD = 3'd4;
  localparam logic [STATE_W-1:0] ST_DIV  = 3'd5;
  localparam logic [STATE_W-1:0] ST_DONE = 3'd6;

  typedef struct packed {
    logic accept;   // latch the incoming price
    logic cfg_wr;   // take a new window length, clear history
    logic rd;       // read the ring entry about to be replaced
    logic upd;      // update moves, sums, counters, ring
    logic mul;      // scale the up sum, form the total
    logic load;     // seed the divider
    logic step;     // one quotient bit
    logic emit;     // load the output register
  } dp_cmd_t;

  typedef struct packed {
    logic full;     // window full after this update
    logic div_done; // all quotient bits formed
    logic out_free; // output register can take a result
  } dp_stat_t;

  function automatic logic [CNT_W-1:0] clamp_window(input logic [WIN_W-1:0] v);
    logic [CNT_W-1:0] w;
    w = CNT_W'(v);
    if (w < CNT_W'(WIN_MIN)) begin
      w = CNT_W'(WIN_MIN);
    end else if (w > CNT_W'(MAX_WINDOW)) begin
      w = CNT_W'(MAX_WINDOW);
    end
    return w;
  endfunction

endpackage

### sv/rsi_sma_ram.sv
// ----------------------------------------------------------------------------
// rsi_sma_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rsi_sma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/rsi_sma_ctrl.sv
// ----------------------------------------------------------------------------
// rsi_sma_ctrl
// Sequencer: one price at a time through read and update, then, once the window is full, scale, load, divide, emit.
// ----------------------------------------------------------------------------
module rsi_sma_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  rsi_sma_pkg::dp_stat_t stat,
  output rsi_sma_pkg::dp_cmd_t  cmd
);

  logic [rsi_sma_pkg::STATE_W-1:0] state, state_next;
  logic idle;

  assign idle      = (state == rsi_sma_pkg::ST_IDLE) && !rst;
  assign cfg_ready = idle;
  // configuration wins a tie so the two channels never transfer together
  assign s_tready  = idle && !cfg_valid;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      rsi_sma_pkg::ST_IDLE: begin
        cmd.cfg_wr = cfg_valid && cfg_ready;
        cmd.accept = s_tvalid && s_tready;
        if (cmd.accept) begin
          state_next = rsi_sma_pkg::ST_READ;
        end
      end
      rsi_sma_pkg::ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = rsi_sma_pkg::ST_UPD;
      end
      rsi_sma_pkg::ST_UPD: begin
        cmd.upd    = 1'b1;
        state_next = stat.full ? rsi_sma_pkg::ST_MUL : rsi_sma_pkg::ST_IDLE;
      end
      rsi_sma_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = rsi_sma_pkg::ST_LOAD;
      end
      rsi_sma_pkg::ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = rsi_sma_pkg::ST_DIV;
      end
      rsi_sma_pkg::ST_DIV: begin
        if (stat.div_done) begin
          state_next = rsi_sma_pkg::ST_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      rsi_sma_pkg::ST_DONE: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = rsi_sma_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rsi_sma_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rsi_sma_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### sv/rsi_sma_dp.sv
// ----------------------------------------------------------------------------
// rsi_sma_dp
// Datapath: move ring, running sums, scaling multiply, restoring divider and
// output register.
// ----------------------------------------------------------------------------
module rsi_sma_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  rsi_sma_pkg::dp_cmd_t               cmd,
  output rsi_sma_pkg::dp_stat_t              stat,
  input  logic [rsi_sma_pkg::PRICE_W-1:0]    in_price,
  input  logic                               in_start,
  input  logic [rsi_sma_pkg::WIN_W-1:0]      cfg_win,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [rsi_sma_pkg::RSI_W-1:0]      out_rsi,
  output logic                               out_flag
);

  localparam int PW = rsi_sma_pkg::PRICE_W;
  localparam int AW = rsi_sma_pkg::ADDR_W;
  localparam int CW = rsi_sma_pkg::CNT_W;
  localparam int SW = rsi_sma_pkg::SUM_W;
  localparam int RW = rsi_sma_pkg::RSI_W;
  localparam int XW = rsi_sma_pkg::PROD_W;
  localparam int DW = rsi_sma_pkg::DIV_CNT_W;

  logic [CW-1:0] window_len;
  logic [PW-1:0] prev_close;
  logic [SW-1:0] up_sum, down_sum;
  logic [CW-1:0] items_seen;
  logic [AW-1:0] ring_pos;
  logic [PW-1:0] price;
  logic          start;

  logic [XW-1:0] prod;
  logic [SW-1:0] total;
  logic          no_loss;
  logic [SW-1:0] rem;
  logic [RW-1:0] quo;
  logic [DW-1:0] div_cnt;

  // ring entry: down move high, up move low
  logic [2*PW-1:0] rd_data;
  logic [2*PW-1:0] wr_data;

  logic [CW-1:0] hist_items, items_next;
  logic [SW-1:0] base_up, base_down, up_next, down_next;
  logic [PW-1:0] up_mv, down_mv;
  logic [AW-1:0] pos_base, pos_eff, pos_next;
  logic [CW-1:0] pos_inc;
  logic          evict;
  logic [SW:0]   trial;
  logic          ge;

  // a new series starts from empty history
  assign hist_items = start ? '0 : items_seen;
  assign base_up    = start ? '0 : up_sum;
  assign base_down  = start ? '0 : down_sum;
  assign pos_base   = start ? '0 : ring_pos;
  assign pos_eff    = (CW'(pos_base) >= window_len) ? '0 : pos_base;

  always_comb begin
    up_mv   = '0;
    down_mv = '0;
    if (hist_items != '0) begin
      if (price >= prev_close) begin
        up_mv = price - prev_close;
      end else begin
        down_mv = prev_close - price;
      end
    end
  end

  assign evict      = hist_items >= window_len;
  assign items_next = evict ? hist_items : hist_items + CW'(1);
  assign up_next    = base_up - (evict ? SW'(rd_data[PW-1:0]) : '0) + SW'(up_mv);
  assign down_next  = base_down - (evict ? SW'(rd_data[2*PW-1:PW]) : '0) + SW'(down_mv);
  assign pos_inc    = CW'(pos_eff) + CW'(1);
  assign pos_next   = (pos_inc >= window_len) ? '0 : pos_inc[AW-1:0];
  assign wr_data    = {down_mv, up_mv};

  rsi_sma_ram #(
    .WIDTH (2 * PW),
    .DEPTH (rsi_sma_pkg::MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.upd),
    .waddr (pos_eff),
    .wdata (wr_data),
    .re    (cmd.rd),
    .raddr (pos_eff),
    .rdata (rd_data)
  );

  // one restoring step: shift in the next numerator bit, subtract if it fits
  assign trial = {rem, quo[RW-1]};
  assign ge    = trial >= {1'b0, total};

  assign stat.full     = items_next >= window_len;
  assign stat.div_done = (div_cnt == '0);
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= CW'(rsi_sma_pkg::WIN_RESET);
      prev_close <= '0;
      up_sum     <= '0;
      down_sum   <= '0;
      items_seen <= '0;
      ring_pos   <= '0;
      div_cnt    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.cfg_wr) begin
        window_len <= rsi_sma_pkg::clamp_window(cfg_win);
        up_sum     <= '0;
        down_sum   <= '0;
        items_seen <= '0;
        ring_pos   <= '0;
      end
      if (cmd.upd) begin
        prev_close <= price;
        up_sum     <= up_next;
        down_sum   <= down_next;
        items_seen <= items_next;
        ring_pos   <= pos_next;
      end
      if (cmd.load) begin
        div_cnt <= DW'(RW);
      end else if (cmd.step) begin
        div_cnt <= div_cnt - DW'(1);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      price <= in_price;
      start <= in_start;
    end
    if (cmd.mul) begin
      prod    <= XW'(up_sum) * XW'(rsi_sma_pkg::RSI_SCALE);
      total   <= up_sum + down_sum;
      no_loss <= (down_sum == '0);
    end
    if (cmd.load) begin
      rem <= prod[XW-1:RW];
      quo <= prod[RW-1:0];
    end else if (cmd.step) begin
      rem <= ge ? SW'(trial - {1'b0, total}) : trial[SW-1:0];
      quo <= {quo[RW-2:0], ge};
    end
    if (cmd.emit) begin
      out_rsi  <= no_loss ? RW'(rsi_sma_pkg::RSI_SCALE) : quo;
      out_flag <= no_loss;
    end
  end

endmodule

### sv/relative_strength_index_sma.sv
// ----------------------------------------------------------------------------
// relative_strength_index_sma
// Relative strength index over a moving window of price moves, with a
// controller sequencing a shared datapath and a 15-bit restoring divider.
// ----------------------------------------------------------------------------
// Sequence: a price that completes a window shows its result on m_tvalid
//   after read, update, scale, load, the divide steps plus a finish check
//   and emit.
// Flow: a new price is taken only when the controller is idle again; items
//   taken while the window fills give no result.
// Reset: synchronous rst restores window_len to 15, clears sums, counters,
//   ring position and the output valid flag; ring contents are left as is.
// ----------------------------------------------------------------------------
module relative_strength_index_sma (
  input  logic        clk,
  input  logic        rst,
  // input price stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [23:0] close_price
  input  logic [0:0]  s_tuser,   // [0] series_start
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [14:0] rsi_value, [15] zero
  output logic [0:0]  m_tuser,   // [0] no_losses
  // window length register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data   // [6:0] window_len
);

  rsi_sma_pkg::dp_cmd_t  cmd;
  rsi_sma_pkg::dp_stat_t stat;

  logic [rsi_sma_pkg::RSI_W-1:0] rsi_value;
  logic                          no_losses;

  // Controller: takes a transfer only when idle, so one price is in flight
  // at a time; a finished result waits in the output register and the next
  // price may be taken while it does.
  rsi_sma_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: ring of up/down moves in RAM, running sums, a constant
  // multiply by 25600 and a bit-per-cycle divide of that by the total.
  rsi_sma_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_price  (s_tdata[rsi_sma_pkg::PRICE_W-1:0]),
    .in_start  (s_tuser[0]),
    .cfg_win   (cfg_data),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_rsi   (rsi_value),
    .out_flag  (no_losses)
  );

  // pad the result to whole bytes
  assign m_tdata = {1'b0, rsi_value};
  assign m_tuser = no_losses;

endmodule

### sv/rsi_sma_chk.sv
// ----------------------------------------------------------------------------
// rsi_sma_chk
// Port-level checks for the relative strength index block, bound to the top.
// ----------------------------------------------------------------------------
module rsi_sma_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [0:0]  m_tuser,
  input logic        cfg_ready
);

  // a result held back keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tuser)))
    else $error("result changed while stalled");

  // no losses forces the full-scale value
  a_flag: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[14:0] == 15'd25600))
    else $error("no_losses without full scale");

  // result stays in range and padding is zero
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[14:0] <= 15'd25600) && !m_tdata[15]))
    else $error("result out of range");

  // one price in flight: after a transfer neither channel is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (!s_tready && !cfg_ready))
    else $error("accepted while busy");

  // a new result only comes out of a busy block
  a_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result without work");

endmodule

bind relative_strength_index_sma rsi_sma_chk u_rsi_sma_chk (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tuser   (m_tuser),
  .cfg_ready (cfg_ready)
);
